/* rtl/rational_approximation_cf_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef RATIONAL_APPROXIMATION_CF_ASSERT_SVH
`define RATIONAL_APPROXIMATION_CF_ASSERT_SVH

// Checked at every rising edge outside reset.
`define RAC_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error("rational_approximation_cf assertion failed");

// Checked at every rising edge, reset included.
`define RAC_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("rational_approximation_cf assertion failed");

`endif

/* rtl/rac_pkg.sv */
// Constants and types shared by the rational approximation block.
`timescale 1ns / 1ps
package rac_pkg;
	localparam int FRAC_BITS = 32;
	localparam int INT_BITS  = 16;
	localparam int DEN_BITS  = 24;
	localparam int MAX_TERMS = 48;

	localparam int VAL_W  = INT_BITS + FRAC_BITS;
	localparam int DIV_W  = (FRAC_BITS + 1 > DEN_BITS) ? FRAC_BITS + 1 : DEN_BITS;
	localparam int MUL_W  = DIV_W;
	localparam int P1_W   = DEN_BITS + MUL_W;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int TERM_W = $clog2(MAX_TERMS + 1);

	localparam logic [DIV_W-1:0]    RECIP_LIMIT = DIV_W'(64'h7FFF_FFFF);
	localparam logic [DEN_BITS-1:0] LIM_RESET   = DEN_BITS'(1000);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TERM_GO,
		S_TERM_WAIT,
		S_DIV_WAIT,
		S_K_GO,
		S_K_DIV_WAIT,
		S_K_MUL_GO,
		S_K_MUL_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic mul_start;
		logic div_start;
		logic div_k_sel;
	} ctl_t;
endpackage

/* rtl/rational_approximation_cf.sv */
// Top level of the continued fraction best rational approximation block.
// Usage:
// - The input channel (in_valid/in_ready, value) takes one signed Q16.32 number
//   per transfer; in_ready is high only while no item is being worked on.
// - The output channel (out_valid/out_ready) returns numerator, denominator and
//   error for each input, in order, from an output register.
// - cfg_we writes max_denominator from cfg_wdata; write it only while idle.
// - Each continued fraction term takes a shift-add multiply and a restoring
//   divide plus control steps; the final semiconvergent step adds a
//   restoring divide and a shift-add multiply. An item runs at most 48
//   terms; the bit-serial divider and multiplier set its running time.
// - The next item is taken while the previous result waits in the output
//   register; when the receiver stalls, a finished result holds in the
//   block until the output register frees.
// - Reset clears all control state and sets max_denominator to 1000.
`timescale 1ns / 1ps
module rational_approximation_cf import rac_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] numerator,
	output logic [DEN_BITS-1:0]     denominator,
	output logic                    error,
	input  logic                    cfg_we,
	input  logic [DEN_BITS-1:0]     cfg_wdata
);
	state_t state_q, state_d;
	ctl_t   ctl;

	logic [DEN_BITS-1:0] lim_q;
	logic                neg_q;
	logic [DIV_W-1:0]    q_q, r_q;
	logic [MUL_W-1:0]    ai_q;
	logic [VAL_W-1:0]    a_q, b_q;
	logic [DEN_BITS-1:0] c_q, d_q;
	logic [TERM_W-1:0]   terms_q;

	logic [VAL_W-1:0]    res_num_q;
	logic [DEN_BITS-1:0] res_den_q;
	logic                res_err_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_num_q;
	logic [DEN_BITS-1:0] out_den_q;
	logic                out_err_q;

	logic [VAL_W-1:0] raw, mag;
	logic [DIV_W-1:0] div_a, div_b, quot, rem;
	logic             div_done, mul_done;
	logic [VAL_W-1:0] p0;
	logic [P1_W-1:0]  p1;
	logic             term_fits, recip_break, semi_better;
	logic [VAL_W-1:0] pick_num;
	logic             out_free;

	assign raw = value;
	assign mag = value[VAL_W-1] ? (~raw + 1'b1) : raw;

	assign term_fits   = p1 <= P1_W'(lim_q);
	assign recip_break = (quot > RECIP_LIMIT) || ((quot == RECIP_LIMIT) && (rem != '0));
	// On a tie the semiconvergent wins.
	assign semi_better = !(c_q < p1[DEN_BITS-1:0]);
	assign pick_num    = semi_better ? p0 : a_q;
	assign out_free    = !out_valid_q || out_ready;

	assign div_a = ctl.div_k_sel ? DIV_W'(lim_q - d_q) : q_q;
	assign div_b = ctl.div_k_sel ? DIV_W'(c_q) : r_q;

	rac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	rac_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.mult   (ai_q),
		.x0     (a_q),
		.y0     (b_q),
		.x1     (c_q),
		.y1     (d_q),
		.done   (mul_done),
		.p0     (p0),
		.p1     (p1)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_TERM_GO;
			end
			S_TERM_GO: state_d = S_TERM_WAIT;
			S_TERM_WAIT: begin
				if (mul_done) begin
					if (!term_fits || r_q == '0) state_d = S_K_GO;
					else state_d = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					if (recip_break || terms_q == TERM_W'(MAX_TERMS)) state_d = S_K_GO;
					else state_d = S_TERM_GO;
				end
			end
			S_K_GO: begin
				if (c_q == '0) state_d = S_FIN;
				else state_d = S_K_DIV_WAIT;
			end
			S_K_DIV_WAIT: begin
				if (div_done) state_d = S_K_MUL_GO;
			end
			S_K_MUL_GO: state_d = S_K_MUL_WAIT;
			S_K_MUL_WAIT: begin
				if (mul_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.mul_start = (state_q == S_TERM_GO) || (state_q == S_K_MUL_GO);
		ctl.div_start = ((state_q == S_TERM_WAIT) && mul_done && term_fits && (r_q != '0))
			|| ((state_q == S_K_GO) && (c_q != '0));
		ctl.div_k_sel = (state_q == S_K_GO);
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lim_q   <= LIM_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) lim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					neg_q   <= value[VAL_W-1];
					ai_q    <= MUL_W'(mag[VAL_W-1:FRAC_BITS]);
					r_q     <= DIV_W'(mag[FRAC_BITS-1:0]);
					q_q     <= DIV_W'(1) << FRAC_BITS;
					a_q     <= VAL_W'(1);
					b_q     <= '0;
					c_q     <= '0;
					d_q     <= DEN_BITS'(1);
					terms_q <= '0;
				end
			end
			S_TERM_WAIT: begin
				if (mul_done && term_fits) begin
					a_q     <= p0;
					b_q     <= a_q;
					c_q     <= p1[DEN_BITS-1:0];
					d_q     <= c_q;
					terms_q <= terms_q + 1'b1;
				end
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					q_q  <= r_q;
					r_q  <= rem;
					ai_q <= quot;
				end
			end
			S_K_GO: begin
				if (c_q == '0) begin
					res_num_q <= '0;
					res_den_q <= '0;
					res_err_q <= 1'b1;
				end
			end
			S_K_DIV_WAIT: begin
				if (div_done) ai_q <= quot;
			end
			S_K_MUL_WAIT: begin
				if (mul_done) begin
					res_num_q <= neg_q ? (~pick_num + 1'b1) : pick_num;
					res_den_q <= semi_better ? p1[DEN_BITS-1:0] : c_q;
					res_err_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_num_q <= res_num_q;
			out_den_q <= res_den_q;
			out_err_q <= res_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign numerator   = out_num_q;
	assign denominator = out_den_q;
	assign error       = out_err_q;
endmodule

/* rtl/rac_div.sv */
// Restoring divider that develops one quotient bit per cycle.
`timescale 1ns / 1ps
module rac_div import rac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot,
	output logic [DIV_W-1:0] rem
);
	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q, rem_q, den_q;
	logic [DIV_W:0]   trial, diff;
	logic             fits;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	// The top bit of the difference is the borrow.
	assign fits  = ~diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;
endmodule

/* rtl/rac_mul.sv */
// Shift-add multiplier that forms two products plus offsets, one multiplier bit per cycle.
`timescale 1ns / 1ps
module rac_mul import rac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MUL_W-1:0]    mult,
	input  logic [VAL_W-1:0]    x0,
	input  logic [VAL_W-1:0]    y0,
	input  logic [DEN_BITS-1:0] x1,
	input  logic [DEN_BITS-1:0] y1,
	output logic                done,
	output logic [VAL_W-1:0]    p0,
	output logic [P1_W-1:0]     p1
);
	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MUL_W-1:0] m_q;
	logic [VAL_W-1:0] s0_q, acc0_q;
	logic [P1_W-1:0]  s1_q, acc1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MUL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The first product wraps at the value width; the top level keeps it only when the second product fits the limit.
	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= mult;
			s0_q   <= x0;
			s1_q   <= P1_W'(x1);
			acc0_q <= y0;
			acc1_q <= P1_W'(y1);
		end else if (busy_q) begin
			if (m_q[0]) begin
				acc0_q <= acc0_q + s0_q;
				acc1_q <= acc1_q + s1_q;
			end
			s0_q <= {s0_q[VAL_W-2:0], 1'b0};
			s1_q <= {s1_q[P1_W-2:0], 1'b0};
			m_q  <= {1'b0, m_q[MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign p0   = acc0_q;
	assign p1   = acc1_q;
endmodule

/* rtl/rac_checker.sv */
// Port-level checker for the rational approximation block, with its bind.
`timescale 1ns / 1ps
`include "rational_approximation_cf_assert.svh"
module rac_checker import rac_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [VAL_W-1:0] numerator,
	input logic [DEN_BITS-1:0]     denominator,
	input logic                    error
);
	logic in_xfer, out_stall, err_out, good_out, zero_frac;

	assign in_xfer   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign err_out   = out_valid && error;
	assign good_out  = out_valid && !error;
	assign zero_frac = (numerator == '0) && (denominator == '0);

	// An error result carries a zero fraction.
	`RAC_ASSERT(a_err_zero, clk, arst_n, err_out |-> zero_frac)
	// A good result always has a positive denominator.
	`RAC_ASSERT(a_den_pos, clk, arst_n, good_out |-> (denominator != '0))
	// The input closes after a transfer while the item is worked on.
	`RAC_ASSERT(a_busy_after_in, clk, arst_n, in_xfer |=> !in_ready)
	`RAC_ASSERT(a_out_hold, clk, arst_n, out_stall |=> (out_valid && $stable({numerator, denominator, error})))
	`RAC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid)
endmodule

bind rational_approximation_cf rac_checker u_rac_checker (.*);
